### src/obfc_pkg.sv
package obfc_pkg;

    // Decimation: every SKIP_FACTOR-th point of a cloud is scored.
    localparam int SKIP_FACTOR = 10;
    localparam int PHASE_W     = $clog2(SKIP_FACTOR + 1);

    // Configuration register indexes.
    localparam logic [2:0] CFG_OFFSET_X = 3'd0;
    localparam logic [2:0] CFG_OFFSET_Y = 3'd1;
    localparam logic [2:0] CFG_OFFSET_Z = 3'd2;
    localparam logic [2:0] CFG_ANGLE_X  = 3'd3;
    localparam logic [2:0] CFG_ANGLE_Y  = 3'd4;
    localparam logic [2:0] CFG_ANGLE_Z  = 3'd5;
    localparam logic [2:0] CFG_SIGMA    = 3'd6;

    localparam logic [19:0] SIGMA_RESET = 20'd1638;

    // Sine and cosine engine, degrees in Q16, vector in Q24.
    localparam logic signed [26:0] CORDIC_GAIN = 27'sd10188014;
    localparam logic signed [25:0] DEG_90      = 26'sd5898240;
    localparam logic signed [25:0] DEG_180     = 26'sd11796480;
    localparam logic signed [17:0] TERM_ONE    = 18'sd65536;

    // Box half-sizes in mm Q16.
    localparam logic signed [36:0] HALF_X = 37'sd3932160;
    localparam logic signed [36:0] HALF_Y = 37'sd1310720;
    localparam logic signed [36:0] HALF_Z = 37'sd196608;

    localparam logic [62:0] SUM_MAX = {63{1'b1}};

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               last_point;
    } in_word_t;

    typedef struct packed {
        logic [62:0] chi2_sum;
        logic [31:0] points_used;
    } out_word_t;

    function automatic logic signed [25:0] atan_deg(input logic [3:0] i);
        logic signed [25:0] r;
        case (i)
            4'd0:    r = 26'sd2949120;
            4'd1:    r = 26'sd1740967;
            4'd2:    r = 26'sd919879;
            4'd3:    r = 26'sd466945;
            4'd4:    r = 26'sd234379;
            4'd5:    r = 26'sd117304;
            4'd6:    r = 26'sd58666;
            4'd7:    r = 26'sd29335;
            4'd8:    r = 26'sd14668;
            4'd9:    r = 26'sd7334;
            4'd10:   r = 26'sd3667;
            4'd11:   r = 26'sd1833;
            4'd12:   r = 26'sd917;
            4'd13:   r = 26'sd458;
            4'd14:   r = 26'sd229;
            default: r = 26'sd115;
        endcase
        return r;
    endfunction

endpackage

### src/open_box_fit_chi2_accumulator_unit.sv
// A kept point passes rotation, squaring, face minimum and 80 divide steps between
// acceptance and its sum update; a skipped point goes straight to the finish.
// One word at a time: a new word is taken only once the last one is finished, and the
// single shared multiplier and the one-bit-a-cycle divider serve every kept point.
// Reset: synchronous, active low; afterwards the sine and cosine terms are rebuilt,
// and again after each angle write, with s_ready held low.
module open_box_fit_chi2_accumulator_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  obfc_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output obfc_pkg::out_word_t m_data
);

    // Sequencer states. Each item walks through rotation, squaring, face minimum,
    // division and finish; a skipped point goes straight to finish.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CORD = 3'd1;
    localparam logic [2:0] ST_ROT  = 3'd2;
    localparam logic [2:0] ST_SQ   = 3'd3;
    localparam logic [2:0] ST_MIN  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    localparam logic [6:0] DIV_LAST = 7'd79;

    // Configuration registers.
    logic signed [31:0] off_x_reg, off_y_reg, off_z_reg;
    logic signed [24:0] ang_x_reg, ang_y_reg, ang_z_reg;
    logic [19:0]        sigma_reg;

    // Control state.
    logic [2:0]                   state_reg;
    logic [6:0]                   step_reg;
    logic [1:0]                   rot_reg;
    logic [1:0]                   cord_idx_reg;
    logic                         cord_wait_reg;
    logic                         dirty_reg;
    logic [obfc_pkg::PHASE_W-1:0] phase_reg;
    logic [62:0]                  acc_reg;
    logic [31:0]                  cnt_reg;
    logic                         m_valid_reg;

    // Datapath registers.
    logic signed [17:0] term_reg [6];
    logic signed [35:0] x_reg, y_reg, z_reg;
    logic               keep_reg, last_reg;
    logic signed [69:0] prod_reg;
    logic signed [55:0] acc_a_reg, acc_b_reg;
    logic [61:0]        sq_reg [6];
    logic [63:0]        best_reg;
    logic [39:0]        s2_reg;
    logic [39:0]        rem_reg;
    logic [79:0]        num_reg;
    logic [62:0]        quo_reg;
    logic               sat_reg;
    obfc_pkg::out_word_t m_data_reg;

    // Sine and cosine engine.
    logic               cord_start;
    logic               cord_done;
    logic signed [24:0] cord_angle;
    logic signed [17:0] cord_cos, cord_sin;

    obfc_sincos u_sincos (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cord_start),
        .angle    (cord_angle),
        .done     (cord_done),
        .cos_term (cord_cos),
        .sin_term (cord_sin)
    );

    assign cord_start = (state_reg == ST_CORD) && !cord_wait_reg;

    always_comb begin
        case (cord_idx_reg)
            2'd0:    cord_angle = ang_x_reg;
            2'd1:    cord_angle = ang_y_reg;
            default: cord_angle = ang_z_reg;
        endcase
    end

    // Rounding of a Q32 product sum back to Q16.
    function automatic logic signed [35:0] rnd16(input logic signed [55:0] a);
        logic signed [55:0] t;
        t = a + 56'sd32768;
        return t[51:16];
    endfunction

    // Absolute distance, limited to the largest positive 32-bit value.
    function automatic logic [30:0] clip_abs(input logic signed [36:0] d);
        logic [36:0] m;
        m = d[36] ? 37'(-d) : 37'(d);
        return (m > 37'd2147483647) ? 31'h7FFFFFFF : m[30:0];
    endfunction

    // Shared multiplier operand selection.
    logic signed [36:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [35:0] rot_u, rot_v;
    logic signed [17:0] rot_c, rot_s;
    logic signed [36:0] face_d;
    logic [19:0]        sig_eff;

    assign sig_eff = (sigma_reg == 20'd0) ? 20'd1 : sigma_reg;

    always_comb begin
        rot_c = term_reg[{rot_reg, 1'b0}];
        rot_s = term_reg[{rot_reg, 1'b1}];
        case (rot_reg)
            2'd0: begin
                rot_u = y_reg;
                rot_v = z_reg;
            end
            2'd1: begin
                rot_u = x_reg;
                rot_v = z_reg;
            end
            default: begin
                rot_u = x_reg;
                rot_v = y_reg;
            end
        endcase
        case (step_reg[2:0])
            3'd0:    face_d = 37'(x_reg) - obfc_pkg::HALF_X;
            3'd1:    face_d = 37'(x_reg) + obfc_pkg::HALF_X;
            3'd2:    face_d = 37'(y_reg) - obfc_pkg::HALF_Y;
            3'd3:    face_d = 37'(y_reg) + obfc_pkg::HALF_Y;
            3'd4:    face_d = 37'(z_reg) - obfc_pkg::HALF_Z;
            default: face_d = 37'(z_reg) + obfc_pkg::HALF_Z;
        endcase
        mul_a = 37'sd0;
        mul_b = 33'sd0;
        case (state_reg)
            ST_ROT: begin
                case (step_reg[2:0])
                    3'd0: begin
                        mul_a = 37'(rot_u);
                        mul_b = 33'(rot_c);
                    end
                    3'd1: begin
                        mul_a = 37'(rot_v);
                        mul_b = 33'(rot_s);
                    end
                    3'd2: begin
                        mul_a = 37'(rot_v);
                        mul_b = 33'(rot_c);
                    end
                    3'd3: begin
                        mul_a = 37'(rot_u);
                        mul_b = 33'(rot_s);
                    end
                    default: begin
                        mul_a = 37'sd0;
                        mul_b = 33'sd0;
                    end
                endcase
            end
            ST_SQ: begin
                mul_a = $signed({6'd0, clip_abs(face_d)});
                mul_b = $signed({2'd0, clip_abs(face_d)});
            end
            ST_MIN: begin
                mul_a = $signed({17'd0, sig_eff});
                mul_b = $signed({13'd0, sig_eff});
            end
            default: begin
                mul_a = 37'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    // Rotation accumulate and write-back terms. The Y rotation subtracts in the
    // first sum; the X and Z rotations subtract in the second.
    logic signed [55:0] prod_lo;
    logic signed [55:0] acc_b_sum;
    logic signed [35:0] new_u, new_v;

    assign prod_lo   = prod_reg[55:0];
    assign acc_b_sum = (rot_reg == 2'd1) ? acc_b_reg + prod_lo : acc_b_reg - prod_lo;
    assign new_u     = rnd16(acc_a_reg);
    assign new_v     = rnd16(acc_b_sum);

    // Per-axis outside distances and the face candidate for this minimum step.
    // The +y face is open and never a candidate.
    logic [61:0] out_x, out_y, out_z;
    logic [63:0] cand, best_min;

    always_comb begin
        out_x = 62'd0;
        out_y = 62'd0;
        out_z = 62'd0;
        if (37'(x_reg) > obfc_pkg::HALF_X) begin
            out_x = sq_reg[0];
        end else if (37'(x_reg) < -obfc_pkg::HALF_X) begin
            out_x = sq_reg[1];
        end
        if (37'(y_reg) > obfc_pkg::HALF_Y) begin
            out_y = sq_reg[2];
        end else if (37'(y_reg) < -obfc_pkg::HALF_Y) begin
            out_y = sq_reg[3];
        end
        if (37'(z_reg) > obfc_pkg::HALF_Z) begin
            out_z = sq_reg[4];
        end else if (37'(z_reg) < -obfc_pkg::HALF_Z) begin
            out_z = sq_reg[5];
        end
        case (step_reg[2:0])
            3'd0:    cand = 64'(sq_reg[3]) + 64'(out_x) + 64'(out_z);
            3'd1:    cand = 64'(sq_reg[0]) + 64'(out_y) + 64'(out_z);
            3'd2:    cand = 64'(sq_reg[1]) + 64'(out_y) + 64'(out_z);
            3'd3:    cand = 64'(sq_reg[4]) + 64'(out_x) + 64'(out_y);
            default: cand = 64'(sq_reg[5]) + 64'(out_x) + 64'(out_y);
        endcase
        if (step_reg == 7'd0 || cand < best_reg) begin
            best_min = cand;
        end else begin
            best_min = best_reg;
        end
    end

    // Restoring division step: one quotient bit of (best * 2^16) / sigma^2 a cycle.
    logic [40:0] div_part;
    logic        div_bit;
    logic [39:0] div_rem;

    always_comb begin
        div_part = {rem_reg, num_reg[79]};
        div_bit  = (div_part >= {1'b0, s2_reg});
        div_rem  = div_bit ? 40'(div_part - {1'b0, s2_reg}) : div_part[39:0];
    end

    // Finish: saturating accumulate and saturating count.
    logic [62:0] term_val;
    logic [63:0] acc_sum;
    logic [62:0] acc_new;
    logic [31:0] cnt_new;
    logic        out_free;

    assign term_val = sat_reg ? obfc_pkg::SUM_MAX : quo_reg;
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, term_val};
    assign acc_new  = !keep_reg ? acc_reg : (acc_sum[63] ? obfc_pkg::SUM_MAX : acc_sum[62:0]);
    assign cnt_new  = (keep_reg && cnt_reg != 32'hFFFFFFFF) ? cnt_reg + 32'd1 : cnt_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == ST_IDLE) && !dirty_reg;

    logic accept;
    logic angle_wr;
    assign accept   = s_valid && s_ready;
    assign angle_wr = cfg_wr_en && (cfg_index == obfc_pkg::CFG_ANGLE_X ||
                                    cfg_index == obfc_pkg::CFG_ANGLE_Y ||
                                    cfg_index == obfc_pkg::CFG_ANGLE_Z);

    // Configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_x_reg <= 32'sd0;
            off_y_reg <= 32'sd0;
            off_z_reg <= 32'sd0;
            ang_x_reg <= 25'sd0;
            ang_y_reg <= 25'sd0;
            ang_z_reg <= 25'sd0;
            sigma_reg <= obfc_pkg::SIGMA_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                obfc_pkg::CFG_OFFSET_X: off_x_reg <= cfg_wr_data;
                obfc_pkg::CFG_OFFSET_Y: off_y_reg <= cfg_wr_data;
                obfc_pkg::CFG_OFFSET_Z: off_z_reg <= cfg_wr_data;
                obfc_pkg::CFG_ANGLE_X:  ang_x_reg <= cfg_wr_data[24:0];
                obfc_pkg::CFG_ANGLE_Y:  ang_y_reg <= cfg_wr_data[24:0];
                obfc_pkg::CFG_ANGLE_Z:  ang_z_reg <= cfg_wr_data[24:0];
                obfc_pkg::CFG_SIGMA:    sigma_reg <= cfg_wr_data[19:0];
                default: ;
            endcase
        end
    end

    // Main sequencer.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= 7'd0;
            rot_reg       <= 2'd0;
            cord_idx_reg  <= 2'd0;
            cord_wait_reg <= 1'b0;
            dirty_reg     <= 1'b1;
            phase_reg     <= '0;
            acc_reg       <= 63'd0;
            cnt_reg       <= 32'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (dirty_reg) begin
                        dirty_reg     <= 1'b0;
                        cord_idx_reg  <= 2'd0;
                        cord_wait_reg <= 1'b0;
                        state_reg     <= ST_CORD;
                    end else if (accept) begin
                        x_reg    <= 36'(s_data.point_x) - 36'(off_x_reg);
                        y_reg    <= 36'(s_data.point_y) - 36'(off_y_reg);
                        z_reg    <= 36'(s_data.point_z) - 36'(off_z_reg);
                        keep_reg <= (phase_reg == '0);
                        last_reg <= s_data.last_point;
                        if (s_data.last_point ||
                            phase_reg == obfc_pkg::PHASE_W'(obfc_pkg::SKIP_FACTOR - 1)) begin
                            phase_reg <= '0;
                        end else begin
                            phase_reg <= phase_reg + 1'b1;
                        end
                        step_reg  <= 7'd0;
                        rot_reg   <= 2'd0;
                        state_reg <= (phase_reg == '0) ? ST_ROT : ST_FIN;
                    end
                end
                ST_CORD: begin
                    if (!cord_wait_reg) begin
                        cord_wait_reg <= 1'b1;
                    end else if (cord_done) begin
                        term_reg[{cord_idx_reg, 1'b0}] <= cord_cos;
                        term_reg[{cord_idx_reg, 1'b1}] <= cord_sin;
                        cord_wait_reg <= 1'b0;
                        if (cord_idx_reg == 2'd2) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            cord_idx_reg <= cord_idx_reg + 2'd1;
                        end
                    end
                end
                ST_ROT: begin
                    step_reg <= step_reg + 7'd1;
                    case (step_reg[2:0])
                        3'd1: acc_a_reg <= prod_lo;
                        3'd2: acc_a_reg <= (rot_reg == 2'd1) ? acc_a_reg - prod_lo
                                                             : acc_a_reg + prod_lo;
                        3'd3: acc_b_reg <= prod_lo;
                        3'd4: begin
                            case (rot_reg)
                                2'd0: begin
                                    y_reg <= new_u;
                                    z_reg <= new_v;
                                end
                                2'd1: begin
                                    x_reg <= new_u;
                                    z_reg <= new_v;
                                end
                                default: begin
                                    x_reg <= new_u;
                                    y_reg <= new_v;
                                end
                            endcase
                            step_reg <= 7'd0;
                            if (rot_reg == 2'd2) begin
                                state_reg <= ST_SQ;
                            end else begin
                                rot_reg <= rot_reg + 2'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_SQ: begin
                    if (step_reg != 7'd0) begin
                        sq_reg[3'(step_reg - 7'd1)] <= prod_reg[61:0];
                    end
                    if (step_reg == 7'd6) begin
                        step_reg  <= 7'd0;
                        state_reg <= ST_MIN;
                    end else begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                ST_MIN: begin
                    best_reg <= best_min;
                    if (step_reg == 7'd1) begin
                        s2_reg <= prod_reg[39:0];
                    end
                    if (step_reg == 7'd4) begin
                        num_reg   <= {best_min, 16'd0};
                        rem_reg   <= 40'd0;
                        quo_reg   <= 63'd0;
                        sat_reg   <= 1'b0;
                        step_reg  <= 7'd0;
                        state_reg <= ST_DIV;
                    end else begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                ST_DIV: begin
                    rem_reg <= div_rem;
                    num_reg <= {num_reg[78:0], 1'b0};
                    quo_reg <= {quo_reg[61:0], div_bit};
                    sat_reg <= sat_reg | quo_reg[62];
                    if (step_reg == DIV_LAST) begin
                        state_reg <= ST_FIN;
                    end else begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                ST_FIN: begin
                    if (!last_reg) begin
                        acc_reg   <= acc_new;
                        cnt_reg   <= cnt_new;
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        // End of cloud: publish the totals and start the next cloud empty.
                        m_data_reg.chi2_sum    <= acc_new;
                        m_data_reg.points_used <= cnt_new;
                        m_valid_reg            <= 1'b1;
                        acc_reg                <= 63'd0;
                        cnt_reg                <= 32'd0;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (angle_wr) begin
                dirty_reg <= 1'b1;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after accepting a word");

    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (s2_reg != 40'd0))
        else $error("divide started with a zero sigma square");

    a_no_accept_in_trig: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORD) |-> !s_ready)
        else $error("input ready while rotation terms are rebuilt");

    a_angle_marks_dirty: assert property (@(posedge aclk) disable iff (!aresetn)
        angle_wr |=> dirty_reg)
        else $error("angle write did not schedule a term rebuild");
`endif

endmodule

### src/obfc_sincos.sv
module obfc_sincos (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [24:0] angle,
    output logic               done,
    output logic signed [17:0] cos_term,
    output logic signed [17:0] sin_term
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [3:0]         iter_reg, iter_next;
    logic signed [26:0] x_reg, x_next;
    logic signed [26:0] y_reg, y_next;
    logic signed [25:0] z_reg, z_next;
    logic               neg_reg, neg_next;
    logic signed [25:0] z_in;

    // Round Q24 to Q16, clamp to plus or minus one and fold the half-turn sign back in.
    function automatic logic signed [17:0] to_term(input logic signed [26:0] v,
                                                   input logic neg);
        logic signed [26:0] r;
        r = (v + 27'sd128) >>> 8;
        if (r > 27'sd65536) begin
            r = 27'sd65536;
        end else if (r < -27'sd65536) begin
            r = -27'sd65536;
        end
        if (neg) begin
            r = -r;
        end
        return r[17:0];
    endfunction

    always_comb begin
        z_in      = 26'(angle);
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            iter_next = 4'd0;
            x_next    = obfc_pkg::CORDIC_GAIN;
            y_next    = 27'sd0;
            neg_next  = 1'b0;
            z_next    = z_in;
            if (z_in > obfc_pkg::DEG_90) begin
                z_next   = z_in - obfc_pkg::DEG_180;
                neg_next = 1'b1;
            end else if (z_in < -obfc_pkg::DEG_90) begin
                z_next   = z_in + obfc_pkg::DEG_180;
                neg_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (!z_reg[25]) begin
                x_next = x_reg - (y_reg >>> iter_reg);
                y_next = y_reg + (x_reg >>> iter_reg);
                z_next = z_reg - obfc_pkg::atan_deg(iter_reg);
            end else begin
                x_next = x_reg + (y_reg >>> iter_reg);
                y_next = y_reg - (x_reg >>> iter_reg);
                z_next = z_reg + obfc_pkg::atan_deg(iter_reg);
            end
            iter_next = iter_reg + 4'd1;
            if (iter_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign cos_term = to_term(x_reg, neg_reg);
    assign sin_term = to_term(y_reg, neg_reg);

endmodule
